// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl of the sort engine
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define BSE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication, checked out of reset
`define BSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define BSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/bse_pkg.sv =====
// package of the sort engine: default sizes, sequencer states, control struct
// no dependencies
package bse_pkg;

    // default store depth and element width
    localparam int BSE_DEPTH       = 64;
    localparam int BSE_VALUE_WIDTH = 32;

    // sequencer states
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_INIT,
        ST_PASS_FIRST,
        ST_PASS_RUN,
        ST_PASS_FLUSH,
        ST_OUT_LOAD,
        ST_OUT_HOLD
    } t_bse_state;

    // store write data source
    typedef enum logic [1:0] {
        WSEL_INPUT,
        WSEL_MIN,
        WSEL_CARRY
    } t_bse_wsel;

    // carry register load source
    typedef enum logic {
        CSEL_RDATA,
        CSEL_MAX
    } t_bse_csel;

    // control from sequencer to datapath
    typedef struct packed {
        logic      in_ready;
        logic      out_valid;
        logic      we;
        t_bse_wsel wsel;
        logic      carry_load;
        t_bse_csel carry_sel;
        logic      out_load;
        logic      out_last;
        logic      out_ovf;
    } t_bse_ctrl;

endpackage

// ===== hw/rtl/bse_stream_ifs.sv =====
// valid/ready stream interfaces for the input and result channels
// depends on bse_pkg for the default element width
interface bse_in_if #(
    parameter int VALUE_WIDTH = bse_pkg::BSE_VALUE_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface bse_out_if #(
    parameter int VALUE_WIDTH = bse_pkg::BSE_VALUE_WIDTH
) ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] sorted_value;
    logic                          last_result;
    logic                          overflow;

    modport source (output valid, output sorted_value, output last_result,
                    output overflow, input ready);
    modport sink   (input valid, input sorted_value, input last_result,
                    input overflow, output ready);
endinterface

// ===== hw/rtl/bse_cmp_unit.sv =====
// shared compare unit: signed greater-than with min and max select
// depends on bse_pkg for the default element width
module bse_cmp_unit #(
    parameter int VALUE_WIDTH = bse_pkg::BSE_VALUE_WIDTH
) (
    input  logic signed [VALUE_WIDTH-1:0] i_a,
    input  logic signed [VALUE_WIDTH-1:0] i_b,
    output logic                          o_gt,
    output logic signed [VALUE_WIDTH-1:0] o_min,
    output logic signed [VALUE_WIDTH-1:0] o_max
);
    // strict compare keeps equal values in order
    assign o_gt  = (i_a > i_b);
    assign o_min = o_gt ? i_b : i_a;
    assign o_max = o_gt ? i_a : i_b;
endmodule

// ===== hw/rtl/bse_ctrl.sv =====
// sequencer of the sort engine: load, bubble passes, readout
// depends on bse_pkg and assert_macros.svh
`include "assert_macros.svh"

module bse_ctrl #(
    parameter int DEPTH = bse_pkg::BSE_DEPTH,
    localparam int AW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_last,
    input  logic               i_out_ready,
    input  logic               i_gt,
    output bse_pkg::t_bse_ctrl o_ctrl,
    output logic [AW-1:0]      o_waddr,
    output logic [AW-1:0]      o_raddr
);
    import bse_pkg::*;

    t_bse_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_pass_len, n_pass_len;
    logic          r_swap, n_swap;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_out_idx, n_out_idx;

    logic          in_fire;
    logic          out_fire;
    logic          full;
    logic          last_now;
    logic [CW-1:0] count_after;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] idx_dec;
    logic [CW-1:0] out_idx_inc;

    // handshake and index helpers
    assign in_fire     = i_in_valid && (r_state == ST_LOAD);
    assign out_fire    = i_out_ready && (r_state == ST_OUT_HOLD);
    assign full        = (r_count == CW'(DEPTH));
    assign count_after = full ? r_count : r_count + CW'(1);
    assign last_now    = (r_out_idx == r_count - CW'(1));
    assign idx_inc     = r_idx + CW'(1);
    assign idx_dec     = r_idx - CW'(1);
    assign out_idx_inc = r_out_idx + CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (in_fire && i_in_last) n_state = ST_PASS_INIT;
            end
            ST_PASS_INIT: begin
                n_state = (r_pass_len == '0) ? ST_OUT_LOAD : ST_PASS_FIRST;
            end
            ST_PASS_FIRST: begin
                n_state = ST_PASS_RUN;
            end
            ST_PASS_RUN: begin
                if (r_idx == r_pass_len) n_state = ST_PASS_FLUSH;
            end
            ST_PASS_FLUSH: begin
                n_state = r_swap ? ST_PASS_INIT : ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
                n_state = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (out_fire) n_state = last_now ? ST_LOAD : ST_OUT_LOAD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // datapath control and store addresses
    always_comb begin
        o_ctrl  = '0;
        o_waddr = '0;
        o_raddr = '0;
        case (r_state)
            ST_LOAD: begin
                o_ctrl.in_ready = 1'b1;
                o_ctrl.we       = in_fire && !full;
                o_ctrl.wsel     = WSEL_INPUT;
                o_waddr         = r_count[AW-1:0];
            end
            ST_PASS_INIT: begin
                o_raddr = '0;
            end
            ST_PASS_FIRST: begin
                o_ctrl.carry_load = 1'b1;
                o_ctrl.carry_sel  = CSEL_RDATA;
                o_raddr           = AW'(1);
            end
            ST_PASS_RUN: begin
                // smaller of the pair settles, larger keeps bubbling
                o_ctrl.we         = 1'b1;
                o_ctrl.wsel       = WSEL_MIN;
                o_ctrl.carry_load = 1'b1;
                o_ctrl.carry_sel  = CSEL_MAX;
                o_waddr           = idx_dec[AW-1:0];
                o_raddr           = idx_inc[AW-1:0];
            end
            ST_PASS_FLUSH: begin
                o_ctrl.we   = 1'b1;
                o_ctrl.wsel = WSEL_CARRY;
                o_waddr     = r_pass_len[AW-1:0];
                o_raddr     = '0;
            end
            ST_OUT_LOAD: begin
                o_ctrl.out_load = 1'b1;
                o_ctrl.out_last = last_now;
                o_ctrl.out_ovf  = r_ovf;
            end
            ST_OUT_HOLD: begin
                o_ctrl.out_valid = 1'b1;
                o_raddr          = out_idx_inc[AW-1:0];
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

    // counters and flags
    always_comb begin
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_pass_len = r_pass_len;
        n_swap     = r_swap;
        n_idx      = r_idx;
        n_out_idx  = r_out_idx;
        case (r_state)
            ST_LOAD: begin
                if (in_fire) begin
                    if (full) n_ovf = 1'b1;
                    else n_count = r_count + CW'(1);
                    if (i_in_last) n_pass_len = count_after - CW'(1);
                end
            end
            ST_PASS_INIT: begin
                n_swap    = 1'b0;
                n_idx     = CW'(1);
                n_out_idx = '0;
            end
            ST_PASS_RUN: begin
                if (i_gt) n_swap = 1'b1;
                n_idx = idx_inc;
            end
            ST_PASS_FLUSH: begin
                if (r_swap) n_pass_len = r_pass_len - CW'(1);
                n_out_idx = '0;
            end
            ST_OUT_HOLD: begin
                if (out_fire) begin
                    if (last_now) begin
                        n_count    = '0;
                        n_ovf      = 1'b0;
                        n_pass_len = '0;
                        n_swap     = 1'b0;
                        n_out_idx  = '0;
                    end else begin
                        n_out_idx = out_idx_inc;
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_pass_len <= '0;
            r_swap     <= 1'b0;
            r_idx      <= '0;
            r_out_idx  <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_pass_len <= n_pass_len;
            r_swap     <= n_swap;
            r_idx      <= n_idx;
            r_out_idx  <= n_out_idx;
        end
    end

    // checks
    `BSE_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "count over depth")
    `BSE_ASSERT_IMPLY(a_pass_short, i_clk, i_rst_n, r_state != ST_LOAD, r_pass_len < r_count, "pass too long")
    `BSE_ASSERT_IMPLY(a_run_idx, i_clk, i_rst_n, r_state == ST_PASS_RUN, (r_idx != '0) && (r_idx <= r_pass_len), "pass index out of range")
    `BSE_ASSERT_NEXT(a_set_close, i_clk, i_rst_n, out_fire && last_now, (r_count == '0) && !r_ovf && (r_state == ST_LOAD), "set not closed")

endmodule

// ===== hw/rtl/bubble_sort_engine_unit.sv =====
// Sort engine: collects a set of signed values, sorts it ascending by bubble passes, emits it.
// Loading takes one value per cycle. Sorting runs on one shared comparator and one
// store with a single write and a single registered read port; passes shrink by one and
// stop after a pass with no swap. Readout loads each result into the result register and
// holds it until the sink takes it. Input is not taken during sort and readout.
// Values past DEPTH are dropped and every result of that set carries the overflow flag.
// depends on bse_pkg, bse_stream_ifs, bse_cmp_unit, bse_ctrl
module bubble_sort_engine_unit #(
    parameter int DEPTH       = bse_pkg::BSE_DEPTH,
    parameter int VALUE_WIDTH = bse_pkg::BSE_VALUE_WIDTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bse_in_if.sink    i_in,
    bse_out_if.source o_out
);
    import bse_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_bse_ctrl                     ctrl;
    logic [AW-1:0]                 waddr;
    logic [AW-1:0]                 raddr;
    logic signed [VALUE_WIDTH-1:0] wdata;
    logic                          cmp_gt;
    logic signed [VALUE_WIDTH-1:0] cmp_min;
    logic signed [VALUE_WIDTH-1:0] cmp_max;

    logic signed [VALUE_WIDTH-1:0] r_mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] r_rdata;
    logic signed [VALUE_WIDTH-1:0] r_carry;
    logic signed [VALUE_WIDTH-1:0] r_out_value;
    logic                          r_out_last;
    logic                          r_out_ovf;

    // sequencer
    bse_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_last   (i_in.last_item),
        .i_out_ready (o_out.ready),
        .i_gt        (cmp_gt),
        .o_ctrl      (ctrl),
        .o_waddr     (waddr),
        .o_raddr     (raddr)
    );

    // shared comparator: bubbling carry against the element just read
    bse_cmp_unit #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cmp (
        .i_a   (r_carry),
        .i_b   (r_rdata),
        .o_gt  (cmp_gt),
        .o_min (cmp_min),
        .o_max (cmp_max)
    );

    // store write data select
    always_comb begin
        case (ctrl.wsel)
            WSEL_INPUT: wdata = i_in.value;
            WSEL_MIN:   wdata = cmp_min;
            WSEL_CARRY: wdata = r_carry;
            default:    wdata = r_carry;
        endcase
    end

    // element store, registered read
    always_ff @(posedge i_clk) begin
        if (ctrl.we) r_mem[waddr] <= wdata;
        r_rdata <= r_mem[raddr];
    end

    // carry of the running pass
    always_ff @(posedge i_clk) begin
        if (ctrl.carry_load) begin
            r_carry <= (ctrl.carry_sel == CSEL_RDATA) ? r_rdata : cmp_max;
        end
    end

    // result payload register
    always_ff @(posedge i_clk) begin
        if (ctrl.out_load) begin
            r_out_value <= r_rdata;
            r_out_last  <= ctrl.out_last;
            r_out_ovf   <= ctrl.out_ovf;
        end
    end

    // channel outputs
    assign i_in.ready         = ctrl.in_ready;
    assign o_out.valid        = ctrl.out_valid;
    assign o_out.sorted_value = r_out_value;
    assign o_out.last_result  = r_out_last;
    assign o_out.overflow     = r_out_ovf;

endmodule
